### hdl/c8ie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8ie_pkg
// Shared types and constants for the CHIP-8 instruction execute block.
// ----------------------------------------------------------------------------
package c8ie_pkg;

    localparam int unsigned PC_W   = 12;
    localparam int unsigned VREG_W = 8;
    localparam int unsigned VIDX_W = 4;
    localparam int unsigned VREG_N = 16;

    localparam logic [PC_W-1:0]   RESET_START_ADDR = 12'h200;
    localparam logic [VIDX_W-1:0] FLAG_REG         = 4'hF;
    localparam logic [11:0]       NNN_RETURN       = 12'h0EE;

    // major opcode (top nibble)
    localparam logic [3:0] OP_SYS        = 4'h0;
    localparam logic [3:0] OP_JUMP       = 4'h1;
    localparam logic [3:0] OP_CALL       = 4'h2;
    localparam logic [3:0] OP_SKEQ_IMM   = 4'h3;
    localparam logic [3:0] OP_SKNE_IMM   = 4'h4;
    localparam logic [3:0] OP_SKEQ_REG   = 4'h5;
    localparam logic [3:0] OP_LOAD_IMM   = 4'h6;
    localparam logic [3:0] OP_ADD_IMM    = 4'h7;
    localparam logic [3:0] OP_ALU        = 4'h8;
    localparam logic [3:0] OP_SKNE_REG   = 4'h9;
    localparam logic [3:0] OP_LOAD_INDEX = 4'hA;

    // 8XYn function codes
    localparam logic [3:0] FN_MOV = 4'h0;
    localparam logic [3:0] FN_OR  = 4'h1;
    localparam logic [3:0] FN_AND = 4'h2;
    localparam logic [3:0] FN_XOR = 4'h3;
    localparam logic [3:0] FN_ADD = 4'h4;
    localparam logic [3:0] FN_SUB = 4'h5;
    localparam logic [3:0] FN_SHR = 4'h6;
    localparam logic [3:0] FN_RSB = 4'h7;
    localparam logic [3:0] FN_SHL = 4'hE;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_UNHANDLED = 2'd3
    } status_t;

    // register file write produced by one executed item
    typedef struct packed {
        logic              rw;
        logic [VIDX_W-1:0] num;
        logic [VREG_W-1:0] val;
        logic              fw;
        logic              fval;
    } vwrite_t;

endpackage : c8ie_pkg
`default_nettype wire

### hdl/c8ie_vreg_file.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8ie_vreg_file
// V0..VE in a two-read-port synchronous memory with per-entry valid bits,
// VF in a flop. Reads are registered; a write landing on the read edge is
// forwarded.
// ----------------------------------------------------------------------------
module c8ie_vreg_file (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          rd_en,
    input  wire logic [c8ie_pkg::VIDX_W-1:0]   rd_x,
    input  wire logic [c8ie_pkg::VIDX_W-1:0]   rd_y,
    input  c8ie_pkg::vwrite_t                  wr,
    output logic      [c8ie_pkg::VREG_W-1:0]   vx,
    output logic      [c8ie_pkg::VREG_W-1:0]   vy
);
    import c8ie_pkg::*;

    logic [VREG_W-1:0] mem [VREG_N];
    logic [VREG_N-1:0] vld_reg;
    logic [VREG_W-1:0] vf_reg;

    logic [VREG_W-1:0] rdx_reg, rdy_reg;
    logic              vldx_reg, vldy_reg;
    logic [VIDX_W-1:0] x_reg, y_reg;
    vwrite_t           byp_reg;
    logic              mem_we;

    assign mem_we = wr.rw && (wr.num != FLAG_REG);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr.num] <= wr.val;
        end
        if (rd_en) begin
            rdx_reg <= mem[rd_x];
            rdy_reg <= mem[rd_y];
            x_reg   <= rd_x;
            y_reg   <= rd_y;
            byp_reg <= wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            vldx_reg <= 1'b0;
            vldy_reg <= 1'b0;
            vf_reg   <= '0;
        end else begin
            if (mem_we) begin
                vld_reg[wr.num] <= 1'b1;
            end
            if (rd_en) begin
                vldx_reg <= vld_reg[rd_x];
                vldy_reg <= vld_reg[rd_y];
            end
            // flag write lands last
            if (wr.fw) begin
                vf_reg <= {{(VREG_W-1){1'b0}}, wr.fval};
            end else if (wr.rw && (wr.num == FLAG_REG)) begin
                vf_reg <= wr.val;
            end
        end
    end

    always_comb begin
        priority if (x_reg == FLAG_REG) begin
            vx = vf_reg;
        end else if (byp_reg.rw && (byp_reg.num == x_reg)) begin
            vx = byp_reg.val;
        end else if (vldx_reg) begin
            vx = rdx_reg;
        end else begin
            vx = '0;
        end
    end

    always_comb begin
        priority if (y_reg == FLAG_REG) begin
            vy = vf_reg;
        end else if (byp_reg.rw && (byp_reg.num == y_reg)) begin
            vy = byp_reg.val;
        end else if (vldy_reg) begin
            vy = rdy_reg;
        end else begin
            vy = '0;
        end
    end

endmodule : c8ie_vreg_file
`default_nettype wire

### hdl/c8ie_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8ie_stack
// Return address stack memory, one write and one registered read port.
// A push on the read edge is forwarded (push and next pop hit one entry).
// ----------------------------------------------------------------------------
module c8ie_stack #(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned AW          = 4
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [c8ie_pkg::PC_W-1:0]   wr_data,
    input  wire logic                        rd_en,
    input  wire logic [AW-1:0]               rd_addr,
    output logic      [c8ie_pkg::PC_W-1:0]   rd_data
);
    import c8ie_pkg::*;

    logic [PC_W-1:0] mem [STACK_DEPTH];
    logic [PC_W-1:0] rd_reg;
    logic [PC_W-1:0] byp_data_reg;
    logic            byp_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg       <= mem[rd_addr];
            byp_reg      <= wr_en;
            byp_data_reg <= wr_data;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : rd_reg;

endmodule : c8ie_stack
`default_nettype wire

### hdl/c8ie_exec.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8ie_exec
// Decode and execute of one instruction: next pc, index, stack move,
// register file write and status.
// ----------------------------------------------------------------------------
module c8ie_exec #(
    parameter int unsigned STACK_DEPTH = 16,
    parameter int unsigned CW          = 5,
    parameter int unsigned AW          = 4
) (
    input  wire logic [15:0]                   ins,
    input  wire logic [c8ie_pkg::PC_W-1:0]     pc,
    input  wire logic [c8ie_pkg::PC_W-1:0]     idx,
    input  wire logic [CW-1:0]                 cnt,
    input  wire logic [c8ie_pkg::VREG_W-1:0]   vx,
    input  wire logic [c8ie_pkg::VREG_W-1:0]   vy,
    input  wire logic [c8ie_pkg::PC_W-1:0]     stack_top,
    output logic      [c8ie_pkg::PC_W-1:0]     pc_next,
    output logic      [c8ie_pkg::PC_W-1:0]     idx_next,
    output logic      [CW-1:0]                 cnt_next,
    output logic                               push,
    output logic      [AW-1:0]                 push_addr,
    output logic      [c8ie_pkg::PC_W-1:0]     push_data,
    output c8ie_pkg::vwrite_t                  wr,
    output c8ie_pkg::status_t                  status
);
    import c8ie_pkg::*;

    localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

    logic [3:0]        op, x, n;
    logic [7:0]        nn;
    logic [PC_W-1:0]   nnn, pc_inc, pc_skip;
    logic [VREG_W:0]   sum, dif, rdif;

    assign op      = ins[15:12];
    assign x       = ins[11:8];
    assign n       = ins[3:0];
    assign nn      = ins[7:0];
    assign nnn     = ins[11:0];
    assign pc_inc  = pc + PC_W'(2);
    assign pc_skip = pc + PC_W'(4);
    assign sum     = {1'b0, vx} + {1'b0, vy};
    assign dif     = {1'b0, vx} - {1'b0, vy};
    assign rdif    = {1'b0, vy} - {1'b0, vx};

    assign push_addr = cnt[AW-1:0];
    assign push_data = pc_inc;

    always_comb begin
        pc_next  = pc_inc;
        idx_next = idx;
        cnt_next = cnt;
        push     = 1'b0;
        wr       = '0;
        status   = ST_OK;
        unique case (op)
            OP_SYS: begin
                if (nnn == NNN_RETURN) begin
                    if (cnt == '0) begin
                        status = ST_UNDERFLOW;
                    end else begin
                        cnt_next = cnt - CW'(1);
                        pc_next  = stack_top;
                    end
                end else begin
                    status = ST_UNHANDLED;
                end
            end
            OP_JUMP: pc_next = nnn;
            OP_CALL: begin
                if (cnt >= CNT_FULL) begin
                    status = ST_OVERFLOW;
                end else begin
                    push     = 1'b1;
                    cnt_next = cnt + CW'(1);
                    pc_next  = nnn;
                end
            end
            OP_SKEQ_IMM: if (vx == nn) pc_next = pc_skip;
            OP_SKNE_IMM: if (vx != nn) pc_next = pc_skip;
            OP_SKEQ_REG: if (vx == vy) pc_next = pc_skip;
            OP_SKNE_REG: if (vx != vy) pc_next = pc_skip;
            OP_LOAD_IMM: begin
                wr.rw = 1'b1;
                wr.val = nn;
            end
            OP_ADD_IMM: begin
                wr.rw = 1'b1;
                wr.val = vx + nn;
            end
            OP_ALU: begin
                wr.rw = 1'b1;
                unique case (n)
                    FN_MOV: wr.val = vy;
                    FN_OR:  wr.val = vx | vy;
                    FN_AND: wr.val = vx & vy;
                    FN_XOR: wr.val = vx ^ vy;
                    FN_ADD: begin
                        wr.val = sum[VREG_W-1:0];
                        wr.fw = 1'b1;
                        wr.fval = sum[VREG_W];
                    end
                    FN_SUB: begin
                        wr.val = dif[VREG_W-1:0];
                        wr.fw = 1'b1;
                        wr.fval = ~dif[VREG_W];
                    end
                    FN_SHR: begin
                        wr.val = {1'b0, vx[VREG_W-1:1]};
                        wr.fw = 1'b1;
                        wr.fval = vx[0];
                    end
                    FN_RSB: begin
                        wr.val = rdif[VREG_W-1:0];
                        wr.fw = 1'b1;
                        wr.fval = ~rdif[VREG_W];
                    end
                    FN_SHL: begin
                        wr.val = {vx[VREG_W-2:0], 1'b0};
                        wr.fw = 1'b1;
                        wr.fval = vx[VREG_W-1];
                    end
                    default: begin
                        wr.rw = 1'b0;
                        status = ST_UNHANDLED;
                    end
                endcase
            end
            OP_LOAD_INDEX: idx_next = nnn;
            default: status = ST_UNHANDLED;
        endcase
        if (wr.rw) begin
            wr.num = x;
        end
    end

endmodule : c8ie_exec
`default_nettype wire

### hdl/chip8_instruction_execute_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_instruction_execute_top
// CHIP-8 instruction execute core with V register file and return stack.
// ----------------------------------------------------------------------------
// One instruction item per clock while results are taken. An item is
// accepted into the execute stage, where the V register file and stack
// memories are read; the result moves into the output register once that
// register is empty or its item is taken. The rate is set by the
// read/modify/write of the V register memory, which forwards the previous
// item's write to the next item's operands. Reset needs no clearing pass:
// V registers read as zero until written. Writing cfg_start_address also
// loads the program counter; only do so while no item is in flight.
// ----------------------------------------------------------------------------
module chip8_instruction_execute_top #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_start_address,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_instruction,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [11:0]      m_pc_value,
    output logic [11:0]      m_index_value,
    output logic             m_reg_written,
    output logic [3:0]       m_reg_number,
    output logic [7:0]       m_vreg_data,
    output logic             m_flag_written,
    output logic             m_flag_value,
    output logic [1:0]       m_status
);
    import c8ie_pkg::*;

    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic            accept, ex_fire;
    logic            ex_valid_reg, m_valid_reg;
    logic [15:0]     ins_reg;
    logic [PC_W-1:0] pc_reg, idx_reg;
    logic [CW-1:0]   cnt_reg, cnt_after;

    logic [VREG_W-1:0] vx, vy;
    logic [PC_W-1:0]   stack_top;
    logic [PC_W-1:0]   pc_next, idx_next, push_data;
    logic [CW-1:0]     cnt_next;
    logic              push;
    logic [AW-1:0]     push_addr, pop_addr;
    vwrite_t           ex_wr, vwr;
    status_t           ex_status;

    logic [PC_W-1:0]   out_pc_reg, out_idx_reg;
    vwrite_t           out_wr_reg;
    status_t           out_status_reg;

    assign cfg_ready = 1'b1;
    assign ex_fire   = ex_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !ex_valid_reg || ex_fire;
    assign accept    = s_valid && s_ready;

    // writes only leave the execute stage when it fires
    assign vwr       = ex_fire ? ex_wr : '0;
    assign cnt_after = ex_fire ? cnt_next : cnt_reg;
    assign pop_addr  = AW'(cnt_after - CW'(1));

    c8ie_vreg_file u_vregs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_x    (s_instruction[11:8]),
        .rd_y    (s_instruction[7:4]),
        .wr      (vwr),
        .vx      (vx),
        .vy      (vy)
    );

    c8ie_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (ex_fire && push),
        .wr_addr (push_addr),
        .wr_data (push_data),
        .rd_en   (accept),
        .rd_addr (pop_addr),
        .rd_data (stack_top)
    );

    c8ie_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .CW          (CW),
        .AW          (AW)
    ) u_exec (
        .ins       (ins_reg),
        .pc        (pc_reg),
        .idx       (idx_reg),
        .cnt       (cnt_reg),
        .vx        (vx),
        .vy        (vy),
        .stack_top (stack_top),
        .pc_next   (pc_next),
        .idx_next  (idx_next),
        .cnt_next  (cnt_next),
        .push      (push),
        .push_addr (push_addr),
        .push_data (push_data),
        .wr        (ex_wr),
        .status    (ex_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ex_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pc_reg       <= RESET_START_ADDR;
            idx_reg      <= '0;
            cnt_reg      <= '0;
        end else begin
            if (accept) begin
                ex_valid_reg <= 1'b1;
            end else if (ex_fire) begin
                ex_valid_reg <= 1'b0;
            end
            if (ex_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                pc_reg <= cfg_start_address;
            end else if (ex_fire) begin
                pc_reg <= pc_next;
            end
            if (ex_fire) begin
                idx_reg <= idx_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ins_reg <= s_instruction;
        end
        if (ex_fire) begin
            out_pc_reg     <= pc_next;
            out_idx_reg    <= idx_next;
            out_wr_reg     <= ex_wr;
            out_status_reg <= ex_status;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pc_value     = out_pc_reg;
    assign m_index_value  = out_idx_reg;
    assign m_reg_written  = out_wr_reg.rw;
    assign m_reg_number   = out_wr_reg.num;
    assign m_vreg_data    = out_wr_reg.val;
    assign m_flag_written = out_wr_reg.fw;
    assign m_flag_value   = out_wr_reg.fval;
    assign m_status       = out_status_reg;

endmodule : chip8_instruction_execute_top
`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for chip8_instruction_execute_top. An instruction-level
// predictor of the execute core (PC, V registers, index, return stack) tracks
// every accepted instruction item, and each result item is compared field by
// field. Directed tests cover ALU flags, flow control, skips, stack limits,
// unhandled opcodes and PC wrap. Random traffic follows, with varying
// back-pressure and start addresses.
// ----------------------------------------------------------------------------
module tb;
    import c8ie_pkg::*;

    localparam int unsigned STACK_DEPTH = 16;
    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned RANDOM_ITEMS = 240;

    typedef struct packed {
        logic [11:0] pc;
        logic [11:0] idx;
        logic        rw;
        logic [3:0]  num;
        logic [7:0]  val;
        logic        fw;
        logic        fval;
        status_t     status;
    } insn_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [11:0] cfg_start_address = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_instruction = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [11:0] m_pc_value;
    logic [11:0] m_index_value;
    logic        m_reg_written;
    logic [3:0]  m_reg_number;
    logic [7:0]  m_vreg_data;
    logic        m_flag_written;
    logic        m_flag_value;
    logic [1:0]  m_status;

    // predictor state
    logic [11:0]  cur_pc = RESET_START_ADDR;
    logic [11:0]  idx_reg = '0;
    logic [7:0]   vreg [VREG_N];
    logic [11:0]  ret_stack [STACK_DEPTH];
    int unsigned  stack_cnt = 0;

    insn_result_t results_due [$];
    insn_result_t front_due;
    int           mismatches = 0;
    int unsigned  cycle_cnt = 0;
    int unsigned  send_idle_pct = 9;
    int unsigned  recv_idle_pct = 50;

    chip8_instruction_execute_top #(
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_start_address (cfg_start_address),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_instruction     (s_instruction),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_pc_value        (m_pc_value),
        .m_index_value     (m_index_value),
        .m_reg_written     (m_reg_written),
        .m_reg_number      (m_reg_number),
        .m_vreg_data       (m_vreg_data),
        .m_flag_written    (m_flag_written),
        .m_flag_value      (m_flag_value),
        .m_status          (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still due", $time, results_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Executes one instruction on the predictor state, returns the result item.
    function automatic insn_result_t execute_insn(input logic [15:0] ins);
        insn_result_t r;
        logic [3:0]   op, x, y, fn;
        logic [7:0]   nn, vx, vy;
        logic [11:0]  nnn, next_pc, skip_pc;
        logic [8:0]   sum;
        op = ins[15:12];
        x = ins[11:8];
        y = ins[7:4];
        fn = ins[3:0];
        nn = ins[7:0];
        nnn = ins[11:0];
        vx = vreg[x];
        vy = vreg[y];
        next_pc = cur_pc + 12'd2;
        skip_pc = cur_pc + 12'd4;
        r = '0;
        r.pc = next_pc;
        r.status = ST_OK;
        case (op)
            OP_SYS: begin
                if (nnn != NNN_RETURN) begin
                    r.status = ST_UNHANDLED;
                end else if (stack_cnt == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    stack_cnt--;
                    r.pc = ret_stack[stack_cnt];
                end
            end
            OP_JUMP: r.pc = nnn;
            OP_CALL: begin
                if (stack_cnt >= STACK_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    ret_stack[stack_cnt] = next_pc;
                    stack_cnt++;
                    r.pc = nnn;
                end
            end
            OP_SKEQ_IMM: if (vx == nn) r.pc = skip_pc;
            OP_SKNE_IMM: if (vx != nn) r.pc = skip_pc;
            OP_SKEQ_REG: if (vx == vy) r.pc = skip_pc;
            OP_SKNE_REG: if (vx != vy) r.pc = skip_pc;
            OP_LOAD_IMM: begin
                r.rw = 1'b1;
                r.val = nn;
            end
            OP_ADD_IMM: begin
                r.rw = 1'b1;
                r.val = vx + nn;
            end
            OP_ALU: begin
                r.rw = 1'b1;
                case (fn)
                    FN_MOV: r.val = vy;
                    FN_OR:  r.val = vx | vy;
                    FN_AND: r.val = vx & vy;
                    FN_XOR: r.val = vx ^ vy;
                    FN_ADD: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        r.val = sum[7:0];
                        r.fw = 1'b1;
                        r.fval = sum[8];
                    end
                    FN_SUB: begin
                        r.val = vx - vy;
                        r.fw = 1'b1;
                        r.fval = (vx >= vy);
                    end
                    FN_SHR: begin
                        r.val = vx >> 1;
                        r.fw = 1'b1;
                        r.fval = vx[0];
                    end
                    FN_RSB: begin
                        r.val = vy - vx;
                        r.fw = 1'b1;
                        r.fval = (vy >= vx);
                    end
                    FN_SHL: begin
                        r.val = vx << 1;
                        r.fw = 1'b1;
                        r.fval = vx[7];
                    end
                    default: begin
                        r.rw = 1'b0;
                        r.status = ST_UNHANDLED;
                    end
                endcase
            end
            OP_LOAD_INDEX: idx_reg = nnn;
            default: r.status = ST_UNHANDLED;
        endcase
        if (r.rw) begin
            vreg[x] = r.val;
            r.num = x;
        end
        // flag lands last, so an op on VF leaves VF holding the flag
        if (r.fw) vreg[FLAG_REG] = {7'd0, r.fval};
        cur_pc = r.pc;
        r.idx = idx_reg;
        return r;
    endfunction

    // Mostly well-formed items: balanced call/return, skips that hit, valid ALU ops.
    function automatic logic [15:0] rand_insn();
        int unsigned pick;
        logic [3:0]  x, y, fn;
        logic [7:0]  nn;
        pick = $urandom_range(99);
        x = 4'($urandom_range(15));
        y = 4'($urandom_range(15));
        nn = 8'($urandom_range(255));
        if (pick < 8) return {OP_SYS, NNN_RETURN};
        if (pick < 16) return {OP_CALL, 12'($urandom_range(4095))};
        if (pick < 28) begin
            if ($urandom_range(1)) nn = vreg[x];
            return {($urandom_range(1) != 0) ? OP_SKEQ_IMM : OP_SKNE_IMM, x, nn};
        end
        if (pick < 36) begin
            if ($urandom_range(2) == 0) y = x;
            return {($urandom_range(1) != 0) ? OP_SKEQ_REG : OP_SKNE_REG, x, y,
                    4'($urandom_range(15))};
        end
        if (pick < 60) begin
            pick = $urandom_range(8);
            fn = (pick == 8) ? FN_SHL : 4'(pick);
            return {OP_ALU, x, y, fn};
        end
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h",
                     $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result item, pc 0x%0h status %0d",
                         $time, m_pc_value, m_status);
                mismatches++;
            end else begin
                front_due = results_due.pop_front();
                check_field("pc_value", front_due.pc, m_pc_value);
                check_field("index_value", front_due.idx, m_index_value);
                check_field("reg_written", front_due.rw, m_reg_written);
                check_field("reg_number", front_due.num, m_reg_number);
                check_field("vreg_data", front_due.val, m_vreg_data);
                check_field("flag_written", front_due.fw, m_flag_written);
                check_field("flag_value", front_due.fval, m_flag_value);
                check_field("status", front_due.status, m_status);
            end
        end
    end

    // Valid stays high across back-to-back items; it drops only for a gap.
    task automatic send_insn(input logic [15:0] ins);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_instruction <= ins;
        do @(posedge aclk); while (!s_ready);
        results_due.push_back(execute_insn(ins));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_start_address(input logic [11:0] addr);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_start_address <= addr;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_pc = addr;
    endtask

    task automatic test_flow_ops();
        send_insn({OP_SYS, NNN_RETURN});    // empty stack
        send_insn(16'hA000);
        send_insn(16'hAFFF);
        send_insn(16'h1ABC);
        send_insn(16'h2345);
        send_insn({OP_SYS, NNN_RETURN});
        send_insn(16'h6A55);
        send_insn(16'h3A55);
        send_insn(16'h3A54);
        send_insn(16'h4A55);
        send_insn(16'h4A54);
        send_insn(16'h6B55);
        send_insn(16'h5AB3);                // low nibble ignored
        send_insn(16'h9AB0);
        send_insn(16'h9AC0);
    endtask

    task automatic test_alu_ops();
        send_insn(16'h6AFF);
        send_insn(16'h6B01);
        send_insn(16'h8AB4);                // carry out
        send_insn(16'h8AB5);
        send_insn(16'h8AB7);
        send_insn(16'h6A80);
        send_insn(16'h8A0E);                // top bit shifted out
        send_insn(16'h6A03);
        send_insn(16'h8A06);
        send_insn(16'h8AB0);
        send_insn(16'h8AB1);
        send_insn(16'h8AB2);
        send_insn(16'h8AB3);
        send_insn(16'h7AFF);                // VF untouched
        send_insn(16'h6FF0);
        send_insn(16'h8FB4);                // op on VF itself
        send_insn(16'h8FB7);
    endtask

    task automatic test_unhandled();
        send_insn(16'h00E0);
        send_insn(16'h0123);
        send_insn(16'h8AB8);
        send_insn(16'h8ABD);
        send_insn(16'h8ABF);
        send_insn(16'hB123);
        send_insn(16'hC0FF);
        send_insn(16'hD123);
        send_insn(16'hEFFF);
        send_insn(16'hFFFF);
    endtask

    task automatic test_stack_limits();
        write_start_address(12'h000);
        repeat (STACK_DEPTH + 1) send_insn({OP_CALL, 12'($urandom_range(4095))});
        repeat (STACK_DEPTH + 1) send_insn({OP_SYS, NNN_RETURN});
    endtask

    task automatic test_pc_wrap();
        write_start_address(12'hFFE);
        send_insn(16'h6000);
        write_start_address(12'hFFF);
        send_insn(16'h3000);                // skip across the top
        write_start_address(12'hFFC);
        send_insn(16'h5000);
        write_start_address(12'hFFE);
        send_insn(16'h2100);                // return address wraps to 0
        send_insn({OP_SYS, NNN_RETURN});
    endtask

    task automatic test_random_traffic(input int unsigned send_pct,
                                       input int unsigned recv_pct,
                                       input logic [11:0] start_addr);
        write_start_address(start_addr);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (RANDOM_ITEMS) send_insn(rand_insn());
    endtask

    initial begin
        foreach (vreg[i]) vreg[i] = '0;
        foreach (ret_stack[i]) ret_stack[i] = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_flow_ops();
        test_alu_ops();
        test_unhandled();
        test_stack_limits();
        test_pc_wrap();
        test_random_traffic(9, 50, 12'($urandom_range(4095)));
        test_random_traffic(50, 9, 12'h000);
        test_random_traffic(0, 0, 12'hFFF);
        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
